// ===== rtl/core/mtni_pkg.sv =====
// Package for the markup tag nesting indenter: transaction types, run
// descriptor, character constants and prefix string tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtni_pkg;

    localparam int MAX_DEPTH   = 31;
    localparam int MAX_RESULTS = MAX_DEPTH + 8;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1) + 1;
    localparam int RUN_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic signed [DEPTH_W-1:0] DEPTH_HI    = DEPTH_W'(MAX_DEPTH);
    localparam logic signed [DEPTH_W-1:0] DEPTH_LO    = DEPTH_W'(-(MAX_DEPTH + 1));
    localparam logic signed [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(-1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
    } out_item_t;

    typedef enum logic [1:0] {
        PFX_NONE    = 2'd0,
        PFX_TEXT    = 2'd1,
        PFX_COUNTER = 2'd2,
        PFX_BR      = 2'd3
    } prefix_t;

    // One output run: spaces, then a prefix string, then up to three tail bytes
    typedef struct packed {
        logic [RUN_W-1:0]   total;
        logic [DEPTH_W-1:0] spaces;
        prefix_t            prefix;
        logic [2:0][7:0]    tail;
    } run_desc_t;

    function automatic logic [3:0] prefix_len(input prefix_t sel);
        logic [3:0] len;
        unique case (sel)
            PFX_TEXT:    len = 4'd6;
            PFX_COUNTER: len = 4'd9;
            PFX_BR:      len = 4'd4;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] prefix_char(input prefix_t sel, input logic [3:0] idx);
        logic [7:0] ch;
        ch = CH_SP;
        unique case (sel)
            PFX_TEXT:
            begin
                unique case (idx)
                    4'd0:    ch = 8'h54;
                    4'd1:    ch = 8'h45;
                    4'd2:    ch = 8'h58;
                    4'd3:    ch = 8'h54;
                    4'd4:    ch = 8'h3A;
                    default: ch = CH_SP;
                endcase
            end
            PFX_COUNTER:
            begin
                unique case (idx)
                    4'd0:    ch = 8'h43;
                    4'd1:    ch = 8'h6F;
                    4'd2:    ch = 8'h75;
                    4'd3:    ch = 8'h6E;
                    4'd4:    ch = 8'h74;
                    4'd5:    ch = 8'h65;
                    4'd6:    ch = 8'h72;
                    4'd7:    ch = 8'h3A;
                    default: ch = CH_SP;
                endcase
            end
            PFX_BR:
            begin
                unique case (idx)
                    4'd0:    ch = CH_LT;
                    4'd1:    ch = 8'h42;
                    4'd2:    ch = 8'h52;
                    default: ch = CH_GT;
                endcase
            end
            default: ch = CH_SP;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/markup_tag_nesting_indenter_top.sv =====
// Markup tag nesting indenter, top level: front end, descriptor queue, back end.
// Depends on mtni_pkg, mtni_front, mtni_queue, mtni_back.
//
// Usage:
//  Input side is a queue write port: a transaction (in_data) is taken on a
//  rising edge with push high and full low. Each markup byte or end-of-stream
//  marker is parsed in that same cycle; the front end writes a run descriptor
//  into a four-entry queue. Results come out as a queue read port: out_data is
//  valid while empty is low and is taken on a rising edge with pop high.
//  A run's first byte passes the queue, the work register and the output register.
//  Throughput: the back end produces one listing byte per cycle while its
//  output register is empty or popped, and a run holds 1 to 39 bytes; inputs
//  that produce at most one byte then flow at one per cycle. The back end's byte
//  generator sets the rate; full rises when the queue holds four runs.
//  Reset clears the queue, the output valid flag, the parse phase (whitespace
//  skip) and the depth (-1). A stalled receiver holds out_data steady; the
//  queue then fills and full stops the sender.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_nesting_indenter_top (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  mtni_pkg::in_item_t   in_data,
    output logic                 empty,
    input  wire                  pop,
    output mtni_pkg::out_item_t  out_data
);
    import mtni_pkg::*;

    logic       accept;
    logic       desc_valid;
    run_desc_t  desc;
    run_desc_t  q_data;
    logic       q_empty;
    logic       q_rd;

    assign accept = push && !full;

    mtni_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_data    (in_data),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    mtni_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_valid),
        .wr_data (desc),
        .full    (full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    mtni_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_rd     (q_rd),
        .out_data (out_data),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mtni_front.sv =====
// Front end: parses each input transaction, tracks phase and nesting depth,
// and emits one run descriptor per transaction that produces output. Uses mtni_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtni_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  mtni_pkg::in_item_t   in_data,
    output logic                 desc_valid,
    output mtni_pkg::run_desc_t  desc
);
    import mtni_pkg::*;

    typedef enum logic [8:0] {
        PH_SKIP  = 9'b000000001,
        PH_TEXT  = 9'b000000010,
        PH_OPEN  = 9'b000000100,
        PH_CLOSE = 9'b000001000,
        PH_TAG   = 9'b000010000,
        PH_SLASH = 9'b000100000,
        PH_QUOTE = 9'b001000000,
        PH_QBS   = 9'b010000000,
        PH_QESC  = 9'b100000000
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic signed [DEPTH_W-1:0]  depth_reg, depth_next;

    logic [7:0]                 c;
    logic signed [DEPTH_W-1:0]  depth_up, depth_dn;
    logic signed [DEPTH_W:0]    text_sp;
    logic [DEPTH_W-1:0]         text_spaces, open_spaces;

    phase_t                     tag_phase;
    logic [7:0]                 tag_b;
    logic                       tag_put;

    logic [DEPTH_W-1:0]         mag;
    logic [7:0]                 mag8, tens, ones;

    logic [DEPTH_W-1:0]         d_spaces;
    prefix_t                    d_prefix;
    logic [2:0][7:0]            d_tail;
    logic [1:0]                 d_cnt;
    logic [RUN_W-1:0]           d_total;

    assign c = in_data.in_byte;

    always_comb
    begin
        depth_up    = (depth_reg < DEPTH_HI) ? depth_reg + DEPTH_W'(1) : depth_reg;
        depth_dn    = (depth_reg > DEPTH_LO) ? depth_reg - DEPTH_W'(1) : depth_reg;
        text_sp     = {depth_reg[DEPTH_W-1], depth_reg} + (DEPTH_W+1)'(1);
        text_spaces = (text_sp > 0) ? text_sp[DEPTH_W-1:0] : '0;
        open_spaces = (depth_up > 0) ? depth_up : '0;
    end

    // Byte inside an opening tag, outside any string
    always_comb
    begin
        tag_phase = PH_TAG;
        tag_b     = c;
        tag_put   = 1'b1;
        priority if (c == CH_SLASH)
        begin
            tag_phase = PH_SLASH;
            tag_put   = 1'b0;
        end
        else if (c == CH_QUOTE)
        begin
            tag_phase = PH_QUOTE;
        end
        else if (c == CH_GT)
        begin
            tag_phase = PH_SKIP;
            tag_b     = CH_NL;
        end
        else
        begin
            tag_phase = PH_TAG;
        end
    end

    always_comb
    begin
        mag  = depth_reg[DEPTH_W-1] ? DEPTH_W'(-depth_reg) : depth_reg;
        mag8 = 8'(mag);
        tens = 8'd0;
        ones = mag8;
        for (int k = 1; k <= 5; k++)
        begin
            if (mag8 >= 8'(10 * k))
            begin
                tens = 8'(k);
                ones = mag8 - 8'(10 * k);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        depth_next = depth_reg;
        d_spaces   = '0;
        d_prefix   = PFX_NONE;
        d_tail     = '0;
        d_cnt      = 2'd0;

        if (in_data.end_of_stream)
        begin
            phase_next = PH_SKIP;
            depth_next = DEPTH_RESET;
            d_prefix   = PFX_COUNTER;
            priority if (depth_reg[DEPTH_W-1] && tens != 8'd0)
            begin
                d_tail = {CH_ZERO + ones, CH_ZERO + tens, CH_MINUS};
                d_cnt  = 2'd3;
            end
            else if (depth_reg[DEPTH_W-1])
            begin
                d_tail = {8'd0, CH_ZERO + ones, CH_MINUS};
                d_cnt  = 2'd2;
            end
            else if (tens != 8'd0)
            begin
                d_tail = {8'd0, CH_ZERO + ones, CH_ZERO + tens};
                d_cnt  = 2'd2;
            end
            else
            begin
                d_tail = {16'd0, CH_ZERO + ones};
                d_cnt  = 2'd1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TEXT:
                begin
                    priority if (c == CH_LT)
                    begin
                        d_tail[0]  = CH_NL;
                        d_cnt      = 2'd1;
                        phase_next = PH_OPEN;
                    end
                    else if (c == CH_NL)
                    begin
                        d_prefix = PFX_BR;
                    end
                    else
                    begin
                        d_tail[0] = c;
                        d_cnt     = 2'd1;
                    end
                end
                PH_OPEN:
                begin
                    if (c == CH_SLASH)
                    begin
                        depth_next = depth_dn;
                        phase_next = PH_CLOSE;
                    end
                    else
                    begin
                        depth_next = depth_up;
                        d_spaces   = open_spaces;
                        d_tail[0]  = tag_b;
                        d_cnt      = {1'b0, tag_put};
                        phase_next = tag_phase;
                    end
                end
                PH_CLOSE:
                begin
                    if (c == CH_GT)
                        phase_next = PH_SKIP;
                end
                PH_TAG:
                begin
                    d_tail[0]  = tag_b;
                    d_cnt      = {1'b0, tag_put};
                    phase_next = tag_phase;
                end
                PH_SLASH:
                begin
                    if (c == CH_GT)
                    begin
                        depth_next = depth_dn;
                        d_tail[0]  = CH_NL;
                        d_cnt      = 2'd1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        d_tail[0]  = CH_SLASH;
                        d_tail[1]  = c;
                        d_cnt      = 2'd2;
                        phase_next = PH_TAG;
                    end
                end
                PH_QUOTE:
                begin
                    d_tail[0] = c;
                    d_cnt     = 2'd1;
                    priority if (c == CH_BSL)
                        phase_next = PH_QBS;
                    else if (c == CH_QUOTE)
                        phase_next = PH_TAG;
                    else
                        phase_next = PH_QUOTE;
                end
                PH_QBS:
                begin
                    d_tail[0]  = c;
                    d_cnt      = 2'd1;
                    phase_next = (c == CH_QUOTE) ? PH_QESC : PH_QUOTE;
                end
                PH_QESC:
                begin
                    d_tail[0]  = c;
                    d_cnt      = 2'd1;
                    phase_next = (c == CH_QUOTE) ? PH_TAG : PH_QUOTE;
                end
                default:
                begin
                    priority if (c == CH_SP || c == CH_NL || c == CH_TAB || c == CH_CR)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (c == CH_LT)
                    begin
                        phase_next = PH_OPEN;
                    end
                    else
                    begin
                        d_spaces   = text_spaces;
                        d_prefix   = PFX_TEXT;
                        d_tail[0]  = c;
                        d_cnt      = 2'd1;
                        phase_next = PH_TEXT;
                    end
                end
            endcase
        end

        d_total = RUN_W'(d_spaces) + RUN_W'(prefix_len(d_prefix)) + RUN_W'(d_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            depth_reg <= DEPTH_RESET;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            depth_reg <= depth_next;
        end
    end

    assign desc_valid  = accept && (d_total != '0);
    assign desc.total  = d_total;
    assign desc.spaces = d_spaces;
    assign desc.prefix = d_prefix;
    assign desc.tail   = d_tail;

endmodule

`default_nettype wire

// ===== rtl/core/mtni_queue.sv =====
// Short descriptor queue between the front and back ends.
// Uses mtni_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtni_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  mtni_pkg::run_desc_t  wr_data,
    output logic                 full,
    input  wire                  rd_en,
    output mtni_pkg::run_desc_t  rd_data,
    output logic                 empty
);
    import mtni_pkg::*;

    run_desc_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && !empty))
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (!wr_en && rd_en && !empty)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en && !empty)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtni_back.sv =====
// Back end: expands run descriptors into listing bytes in an output register,
// one per cycle while that register is empty or popped. Uses mtni_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtni_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_empty,
    input  mtni_pkg::run_desc_t  q_data,
    output logic                 q_rd,
    output mtni_pkg::out_item_t  out_data,
    output logic                 empty,
    input  wire                  pop
);
    import mtni_pkg::*;

    logic             work_valid_reg;
    run_desc_t        work_reg, work_next;
    logic [3:0]       pidx_reg, pidx_next;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic             step, last, load;
    logic [7:0]       cur_byte;

    assign step = work_valid_reg && (!out_valid_reg || pop);
    assign last = (work_reg.total == RUN_W'(1));
    assign load = !q_empty && (!work_valid_reg || (step && last));
    assign q_rd = load;

    always_comb
    begin
        work_next       = work_reg;
        pidx_next       = pidx_reg;
        work_next.total = work_reg.total - RUN_W'(1);
        priority if (work_reg.spaces != '0)
        begin
            cur_byte         = CH_SP;
            work_next.spaces = work_reg.spaces - DEPTH_W'(1);
        end
        else if (work_reg.prefix != PFX_NONE)
        begin
            cur_byte = prefix_char(work_reg.prefix, pidx_reg);
            if (pidx_reg == prefix_len(work_reg.prefix) - 4'd1)
            begin
                work_next.prefix = PFX_NONE;
                pidx_next        = 4'd0;
            end
            else
            begin
                pidx_next = pidx_reg + 4'd1;
            end
        end
        else
        begin
            cur_byte       = work_reg.tail[0];
            work_next.tail = {8'd0, work_reg.tail[2:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            work_reg <= q_data;
        else if (step)
            work_reg <= work_next;
        if (step)
        begin
            out_reg.out_byte    <= cur_byte;
            out_reg.last_in_run <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pidx_reg       <= 4'd0;
        end
        else
        begin
            if (load)
                work_valid_reg <= 1'b1;
            else if (step && last)
                work_valid_reg <= 1'b0;

            if (load)
                pidx_reg <= 4'd0;
            else if (step)
                pidx_reg <= pidx_next;

            if (step)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_data = out_reg;
    assign empty    = !out_valid_reg;

endmodule

`default_nettype wire

// ===== verif/markup_tag_nesting_indenter_top_tb.sv =====
// Testbench for markup_tag_nesting_indenter_top: directed, depth-limit, back-pressure
// and random markup tests against a built-in listing predictor.
// Depends on mtni_pkg and the indenter RTL.
`timescale 1ns / 1ps

module markup_tag_nesting_indenter_top_tb;

    import mtni_pkg::*;

    typedef enum logic [3:0] {
        PH_SKIP,
        PH_TEXT,
        PH_OPEN,
        PH_CLOSE,
        PH_TAG,
        PH_SLASH,
        PH_QUOTE,
        PH_QBS,
        PH_QESC
    } listing_phase_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_data;
    logic      empty;
    logic      pop;
    out_item_t out_data;

    markup_tag_nesting_indenter_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    out_item_t                     expected_listing[$];
    listing_phase_t                parse_state = PH_SKIP;
    logic signed [DEPTH_W-1:0]     nest_level  = DEPTH_RESET;
    int                            run_len;
    int                            longest_run = 0;
    int                            items_sent = 0;
    int                            bytes_checked = 0;
    int                            mismatch_count = 0;
    int                            full_cycles = 0;
    int                            burst_left = 0;
    bit                            gaps_on = 1'b1;
    int                            hold_request = 0;
    int                            hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------- listing predictor ----------------

    function automatic void emit(input logic [7:0] b);
        expected_listing.push_back('{out_byte: b, last_in_run: 1'b0});
        run_len++;
    endfunction

    function automatic void emit_str(input string s);
        for (int i = 0; i < s.len(); i++)
            emit(s[i]);
    endfunction

    function automatic void emit_spaces(input int count);
        for (int i = 0; i < count; i++)
            emit(CH_SP);
    endfunction

    function automatic void open_tag_byte(input logic [7:0] c);
        if (c == CH_SLASH)
            parse_state = PH_SLASH;
        else if (c == CH_QUOTE)
        begin
            emit(c);
            parse_state = PH_QUOTE;
        end
        else if (c == CH_GT)
        begin
            emit(CH_NL);
            parse_state = PH_SKIP;
        end
        else
            emit(c);
    endfunction

    function automatic void level_up();
        if (nest_level < DEPTH_HI)
            nest_level = nest_level + DEPTH_W'(1);
    endfunction

    function automatic void level_down();
        if (nest_level > DEPTH_LO)
            nest_level = nest_level - DEPTH_W'(1);
    endfunction

    function automatic void predict_listing(input in_item_t it);
        logic [7:0] c;
        int         mag;
        out_item_t  tail;
        c       = it.in_byte;
        run_len = 0;
        if (it.end_of_stream)
        begin
            emit_str("Counter: ");
            if (nest_level < 0)
            begin
                emit(CH_MINUS);
                mag = -int'(nest_level);
            end
            else
                mag = int'(nest_level);
            emit_str($sformatf("%0d", mag));
            parse_state = PH_SKIP;
            nest_level  = DEPTH_RESET;
        end
        else
        begin
            case (parse_state)
                PH_TEXT:
                begin
                    if (c == CH_LT)
                    begin
                        emit(CH_NL);
                        parse_state = PH_OPEN;
                    end
                    else if (c == CH_NL)
                        emit_str("<BR>");
                    else
                        emit(c);
                end
                PH_OPEN:
                begin
                    if (c == CH_SLASH)
                    begin
                        level_down();
                        parse_state = PH_CLOSE;
                    end
                    else
                    begin
                        level_up();
                        emit_spaces(int'(nest_level));
                        parse_state = PH_TAG;
                        open_tag_byte(c);
                    end
                end
                PH_CLOSE:
                begin
                    if (c == CH_GT)
                        parse_state = PH_SKIP;
                end
                PH_TAG:
                    open_tag_byte(c);
                PH_SLASH:
                begin
                    if (c == CH_GT)
                    begin
                        level_down();
                        emit(CH_NL);
                        parse_state = PH_SKIP;
                    end
                    else
                    begin
                        emit(CH_SLASH);
                        emit(c);
                        parse_state = PH_TAG;
                    end
                end
                PH_QUOTE:
                begin
                    emit(c);
                    if (c == CH_BSL)
                        parse_state = PH_QBS;
                    else if (c == CH_QUOTE)
                        parse_state = PH_TAG;
                end
                PH_QBS:
                begin
                    emit(c);
                    parse_state = (c == CH_QUOTE) ? PH_QESC : PH_QUOTE;
                end
                PH_QESC:
                begin
                    emit(c);
                    parse_state = (c == CH_QUOTE) ? PH_TAG : PH_QUOTE;
                end
                default:
                begin
                    if (c == CH_SP || c == CH_NL || c == CH_TAB || c == CH_CR)
                        parse_state = PH_SKIP;
                    else if (c == CH_LT)
                        parse_state = PH_OPEN;
                    else
                    begin
                        emit_spaces(int'(nest_level) + 1);
                        emit_str("TEXT: ");
                        emit(c);
                        parse_state = PH_TEXT;
                    end
                end
            endcase
        end
        if (run_len > 0)
        begin
            tail = expected_listing.pop_back();
            tail.last_in_run = 1'b1;
            expected_listing.push_back(tail);
        end
        if (run_len > longest_run)
            longest_run = run_len;
    endfunction

    // ---------------- input side ----------------

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push    <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (full)
        begin
            full_cycles++;
            @(posedge clk);
        end
        predict_listing(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{in_byte: b, end_of_stream: 1'b0});
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_eos();
        send_item('{in_byte: 8'($urandom_range(0, 255)), end_of_stream: 1'b1});
    endtask

    // ---------------- output side ----------------

    initial
    begin
        out_item_t want;
        int        rx_cycle;
        int        rx_mode;
        rx_cycle = 0;
        rx_mode  = 0;
        pop      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (expected_listing.size() == 0)
                begin
                    $error("unexpected transaction: out_byte %h last_in_run %b",
                           out_data.out_byte, out_data.last_in_run);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_listing.pop_front();
                    bytes_checked++;
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_data.out_byte);
                        mismatch_count++;
                    end
                    if (out_data.last_in_run !== want.last_in_run)
                    begin
                        $error("last_in_run: expected %b, actual %b",
                               want.last_in_run, out_data.last_in_run);
                        mismatch_count++;
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ~rx_cycle[2];
                endcase
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        send_eos();
        send_text(" h\n");
        send_byte(8'hFF);
        send_text("<p\"\\\"\\\"/\"/>");
        send_text("</\">");
        send_byte(8'h00);
        send_text("<q");
        send_eos();
        send_text("\t\r");
    endtask

    task automatic test_depth_limits();
        send_eos();
        repeat (33) send_text("<a>");
        send_text("z<");
        send_eos();
        repeat (32) send_text("</>");
        send_text("y");
        send_eos();
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        repeat (6) send_text("<ab>");
        send_text("lots of text");
        send_byte(CH_LT);
        send_eos();
    endtask

    task automatic send_quoted();
        int n;
        send_byte(CH_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0:       send_byte(CH_BSL);
                1:       send_text("\\\"");
                2:       send_text("\\\"\"");
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        send_byte(CH_QUOTE);
    endtask

    task automatic random_markup_element();
        int         sel;
        int         n;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
        else if (sel < 16)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       send_byte(CH_SP);
                    1:       send_byte(CH_NL);
                    2:       send_byte(CH_TAB);
                    default: send_byte(CH_CR);
                endcase
            end
        end
        else if (sel < 36)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0:       b = CH_NL;
                    1:       b = 8'($urandom_range(128, 255));
                    default: b = 8'($urandom_range(33, 126));
                endcase
                if (b == CH_LT)
                    b = "x";
                send_byte(b);
            end
        end
        else if (sel < 62)
        begin
            send_byte(CH_LT);
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_GT || b == CH_SLASH || b == CH_QUOTE)
                    b = "n";
                send_byte(b);
            end
            if ($urandom_range(0, 2) == 0)
                send_quoted();
            if ($urandom_range(0, 4) == 0)
            begin
                send_byte(CH_SLASH);
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) == 0)
                send_text("/>");
            else
                send_byte(CH_GT);
        end
        else if (sel < 84)
        begin
            send_text("</");
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_GT)
                    b = CH_QUOTE;
                send_byte(b);
            end
            send_byte(CH_GT);
        end
        else if (sel < 90)
            send_eos();
        else
            send_text("<t>");
    endtask

    task automatic test_random_markup();
        int first;
        first = items_sent;
        while (items_sent - first < 160)
        begin
            gaps_on = ((items_sent / 40) % 3 != 2);
            random_markup_element();
        end
        gaps_on = 1'b1;
        send_eos();
    endtask

    initial
    begin
        int waited;
        rst_n   = 1'b0;
        push    = 1'b0;
        in_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_depth_limits();
        test_backpressure();
        test_random_markup();

        push <= 1'b0;
        waited = 0;
        while (expected_listing.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (expected_listing.size() != 0)
        begin
            $error("%0d listing bytes never arrived", expected_listing.size());
            mismatch_count++;
        end

        $display("%0d transactions in, %0d listing bytes checked, longest run %0d bytes",
                 items_sent, bytes_checked, longest_run);
        $display("covered depth saturation both ways, quoting, self-closing tags, %0d full cycles",
                 full_cycles);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== markup_tag_nesting_indenter_top.f =====
rtl/core/mtni_pkg.sv
rtl/core/mtni_front.sv
rtl/core/mtni_queue.sv
rtl/core/mtni_back.sv
rtl/core/markup_tag_nesting_indenter_top.sv
verif/markup_tag_nesting_indenter_top_tb.sv
